>>> sv/pcps_pkg.sv
// ----------------------------------------------------------------------------
// pcps_pkg
// Shared widths, codes and types of the periodic channel poll scheduler.
// ----------------------------------------------------------------------------
package pcps_pkg;

    localparam int TIME_W       = 48;
    localparam int PERIOD_W     = 32;
    localparam int CH_W         = 3;
    localparam int COUNT_W      = 4;
    localparam int RESULT_LIMIT = 8;
    localparam int PADDR_W      = 3;
    localparam int PDATA_W      = 32;

    localparam logic [TIME_W-1:0] TIME_MAX = '1;

    localparam logic OP_DISPATCH = 1'b0;
    localparam logic OP_LOAD     = 1'b1;

    // word index of the register file (paddr bit 2)
    localparam logic REG_ACTIVE = 1'b0;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_DIV,
        S_UPD,
        S_WB,
        S_LAST
    } t_state;

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [TIME_W-1:0]   deadline;
    } t_entry;

endpackage

>>> sv/pcps_div.sv
// ----------------------------------------------------------------------------
// pcps_div
// Restoring remainder unit: one dividend bit per cycle, all TIME_W bits of the dividend.
// ----------------------------------------------------------------------------
module pcps_div
    import pcps_pkg::*;
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [TIME_W-1:0]   i_dividend,
    input  logic [PERIOD_W-1:0] i_divisor,
    output logic                o_done,
    output logic [PERIOD_W-1:0] o_rem
);

    localparam int CNT_W = $clog2(TIME_W);

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [TIME_W-1:0]   r_dvd;
    logic [PERIOD_W-1:0] r_dsr;
    logic [PERIOD_W-1:0] r_rem;

    logic [PERIOD_W:0]   trial;
    logic [PERIOD_W:0]   diff;
    logic [PERIOD_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_dvd[TIME_W-1]};
        diff  = trial - {1'b0, r_dsr};
        if (trial >= {1'b0, r_dsr}) begin
            n_rem = diff[PERIOD_W-1:0];
        end else begin
            n_rem = trial[PERIOD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(TIME_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[TIME_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

>>> sv/pcps_cfg.sv
// ----------------------------------------------------------------------------
// pcps_cfg
// APB register file: active channel count.
// ----------------------------------------------------------------------------
module pcps_cfg
    import pcps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output logic [COUNT_W-1:0] o_active
);

    logic [COUNT_W-1:0] r_active;
    logic               wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready && (paddr[PADDR_W-1] == REG_ACTIVE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
        end else if (wr_en) begin
            r_active <= pwdata[COUNT_W-1:0];
        end
    end

    always_comb begin
        if (paddr[PADDR_W-1] == REG_ACTIVE) begin
            prdata = PDATA_W'(r_active);
        end else begin
            prdata = '0;
        end
    end

    assign o_active = r_active;

endmodule

>>> sv/periodic_channel_poll_scheduler_unit.sv
// ----------------------------------------------------------------------------
// periodic_channel_poll_scheduler_unit
// Multi-rate channel scheduler: period/deadline table in one RAM, walked on
// each dispatch with a shared remainder unit for the skip-ahead step.
// ----------------------------------------------------------------------------
//  channel   | handshake                  | payload
//  input     | start, busy                | i_op i_now_time i_channel_index
//            |                            | i_period_ticks
//  result    | o_valid (1-cycle strobe)   | o_poll_valid o_polled_channel o_last
//            |                            | o_polled_count o_has_deadline
//            |                            | o_earliest_deadline
//  config    | psel penable pwrite pready | paddr pwdata prdata
//
//  Load: no result, busy stays low.
//  Dispatch: per channel S_READ, S_CHECK, then S_DIV, S_UPD, S_WB if due;
//  the remainder unit (one bit a cycle) sets the per-poll cost.
//  Results leave one per cycle at most; o_valid cannot be held off.
//  Reset is synchronous; table RAM is not cleared.
// ----------------------------------------------------------------------------
module periodic_channel_poll_scheduler_unit
    import pcps_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                i_op,
    input  logic [TIME_W-1:0]   i_now_time,
    input  logic [CH_W-1:0]     i_channel_index,
    input  logic [PERIOD_W-1:0] i_period_ticks,
    output logic                o_valid,
    output logic                o_poll_valid,
    output logic [CH_W-1:0]     o_polled_channel,
    output logic                o_last,
    output logic [COUNT_W-1:0]  o_polled_count,
    output logic                o_has_deadline,
    output logic [TIME_W-1:0]   o_earliest_deadline,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [PADDR_W-1:0]  paddr,
    input  logic [PDATA_W-1:0]  pwdata,
    output logic [PDATA_W-1:0]  prdata,
    output logic                pready
);

    localparam int AW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int LIMIT = (CHANNELS < RESULT_LIMIT) ? CHANNELS : RESULT_LIMIT;

    t_state r_state, n_state;

    logic [COUNT_W-1:0]  r_idx, n_idx;
    logic [COUNT_W-1:0]  r_count, n_count;
    logic                r_pend_v, n_pend_v;
    logic [CH_W-1:0]     r_pend_ch, n_pend_ch;
    logic [TIME_W-1:0]   r_now, n_now;
    logic [PERIOD_W-1:0] r_per, n_per;
    logic [TIME_W-1:0]   r_base, n_base;
    logic [TIME_W-1:0]   r_newdl, n_newdl;
    logic [TIME_W-1:0]   r_earliest, n_earliest;

    logic                r_o_valid, n_o_valid;
    logic                r_o_poll_valid, n_o_poll_valid;
    logic [CH_W-1:0]     r_o_ch, n_o_ch;
    logic                r_o_last, n_o_last;
    logic [COUNT_W-1:0]  r_o_count, n_o_count;
    logic                r_o_has, n_o_has;
    logic [TIME_W-1:0]   r_o_earliest, n_o_earliest;

    t_entry              mem [CHANNELS];
    t_entry              r_rdata;
    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    logic [AW-1:0]       mem_raddr;

    logic [COUNT_W-1:0]  active;
    logic [COUNT_W-1:0]  n_eff;
    logic                accept;
    logic                at_end;
    logic                due;
    logic [PERIOD_W-1:0] eff_per;
    logic [TIME_W:0]     sum;
    logic                div_start;
    logic                div_done;
    logic [PERIOD_W-1:0] div_rem;

    pcps_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_active (active)
    );

    pcps_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_now - r_rdata.deadline),
        .i_divisor  (eff_per),
        .o_done     (div_done),
        .o_rem      (div_rem)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;
    assign n_eff  = (active > COUNT_W'(LIMIT)) ? COUNT_W'(LIMIT) : active;
    assign at_end = (r_idx == n_eff - 1'b1);
    assign due    = (r_rdata.deadline <= r_now);
    assign eff_per = (r_rdata.period == '0) ? PERIOD_W'(1) : r_rdata.period;
    assign sum    = {1'b0, r_base} + (TIME_W + 1)'(r_per);
    assign mem_raddr = AW'(r_idx);

    // table RAM
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept && i_op == OP_DISPATCH) begin
                    n_state = (n_eff == '0) ? S_LAST : S_READ;
                end
            end
            S_READ:  n_state = S_CHECK;
            S_CHECK: begin
                if (due) begin
                    n_state = S_DIV;
                end else begin
                    n_state = at_end ? S_LAST : S_READ;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_UPD;
                end
            end
            S_UPD:  n_state = S_WB;
            S_WB:   n_state = at_end ? S_LAST : S_READ;
            S_LAST: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_idx          = r_idx;
        n_count        = r_count;
        n_pend_v       = r_pend_v;
        n_pend_ch      = r_pend_ch;
        n_now          = r_now;
        n_per          = r_per;
        n_base         = r_base;
        n_newdl        = r_newdl;
        n_earliest     = r_earliest;
        n_o_valid      = 1'b0;
        n_o_poll_valid = 1'b0;
        n_o_ch         = '0;
        n_o_last       = 1'b0;
        n_o_count      = '0;
        n_o_has        = 1'b0;
        n_o_earliest   = '0;
        mem_we         = 1'b0;
        mem_waddr      = AW'(r_idx);
        mem_wdata      = '{period: r_rdata.period, deadline: r_newdl};
        div_start      = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_op == OP_LOAD) begin
                        if (32'(i_channel_index) < CHANNELS) begin
                            mem_we    = 1'b1;
                            mem_waddr = AW'(i_channel_index);
                            mem_wdata = '{period: i_period_ticks, deadline: i_now_time};
                        end
                    end else begin
                        n_now    = i_now_time;
                        n_idx    = '0;
                        n_count  = '0;
                        n_pend_v = 1'b0;
                    end
                end
            end
            S_CHECK: begin
                n_per = eff_per;
                if (due) begin
                    div_start = 1'b1;
                end else begin
                    if (r_idx == '0 || r_rdata.deadline < r_earliest) begin
                        n_earliest = r_rdata.deadline;
                    end
                    if (!at_end) begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_base = r_now - TIME_W'(div_rem);
                end
            end
            S_UPD: begin
                n_newdl = sum[TIME_W] ? TIME_MAX : sum[TIME_W-1:0];
            end
            S_WB: begin
                mem_we = 1'b1;
                if (r_idx == '0 || r_newdl < r_earliest) begin
                    n_earliest = r_newdl;
                end
                if (r_pend_v) begin
                    n_o_valid      = 1'b1;
                    n_o_poll_valid = 1'b1;
                    n_o_ch         = r_pend_ch;
                end
                n_pend_v  = 1'b1;
                n_pend_ch = r_idx[CH_W-1:0];
                n_count   = r_count + 1'b1;
                if (!at_end) begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_LAST: begin
                n_o_valid      = 1'b1;
                n_o_last       = 1'b1;
                n_o_poll_valid = r_pend_v;
                n_o_ch         = r_pend_v ? r_pend_ch : '0;
                n_o_count      = r_pend_v ? r_count : '0;
                n_o_has        = (n_eff != '0);
                n_o_earliest   = (n_eff != '0) ? r_earliest : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_pend_v       <= 1'b0;
            r_o_valid      <= 1'b0;
            r_o_last       <= 1'b0;
            r_o_poll_valid <= 1'b0;
        end else begin
            r_state        <= n_state;
            r_pend_v       <= n_pend_v;
            r_o_valid      <= n_o_valid;
            r_o_last       <= n_o_last;
            r_o_poll_valid <= n_o_poll_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx        <= n_idx;
        r_count      <= n_count;
        r_pend_ch    <= n_pend_ch;
        r_now        <= n_now;
        r_per        <= n_per;
        r_base       <= n_base;
        r_newdl      <= n_newdl;
        r_earliest   <= n_earliest;
        r_o_ch       <= n_o_ch;
        r_o_count    <= n_o_count;
        r_o_has      <= n_o_has;
        r_o_earliest <= n_o_earliest;
    end

    assign o_valid             = r_o_valid;
    assign o_poll_valid        = r_o_poll_valid;
    assign o_polled_channel    = r_o_ch;
    assign o_last              = r_o_last;
    assign o_polled_count      = r_o_count;
    assign o_has_deadline      = r_o_has;
    assign o_earliest_deadline = r_o_earliest;

`ifndef NO_ASSERTIONS
    a_valid_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(busy))
        else $error("result without a dispatch in progress");

    a_last_is_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_last |-> o_valid)
        else $error("last flag without result strobe");

    a_mid_is_poll: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_last) |-> (o_poll_valid && o_polled_count == '0))
        else $error("non-final result is not a bare poll");

    a_last_frees: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |-> !busy)
        else $error("still busy when final result leaves");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("remainder ready outside divide wait");
`endif

endmodule
